// ----- sv/software_timer_slot_scheduler_defines.svh -----
// Assertion macros for the timer slot scheduler.
// Used by the top level; needs a clock named i_clk and reset named i_rst_n in scope.
`ifndef SOFTWARE_TIMER_SLOT_SCHEDULER_DEFINES_SVH
`define SOFTWARE_TIMER_SLOT_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
`define STS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("timer scheduler assertion failed");
`define STS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("timer scheduler assertion failed");
`else
`define STS_ASSERT_IMP(lbl, ante, cons)
`define STS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- sv/sts_pkg.sv -----
// Shared types and constants for the timer slot scheduler.
// No dependencies; used by sts_rem_unit and software_timer_slot_scheduler.
package sts_pkg;

    localparam int SLOTS      = 8;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TASK_W     = 8;
    localparam int PERIOD_W   = 16;
    localparam int BASE_W     = 16;
    localparam int PRESCALE_W = 8;
    localparam int STEP_W     = $clog2(BASE_W);

    localparam logic [PRESCALE_W-1:0] TPC_RESET = PRESCALE_W'(4);

    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_STOP     = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_DISPATCH = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_MISS        = 2'd1,
        ST_ZERO_PERIOD = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REPLY,
        S_CHECK,
        S_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic                start;
        logic [BASE_W-1:0]   dividend;
        logic [PERIOD_W-1:0] divisor;
    } t_rem_req;

    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } t_rem_stat;

endpackage

// ----- sv/sts_rem_unit.sv -----
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on sts_pkg for widths and the request/status structs.
module sts_rem_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sts_pkg::t_rem_req    i_req,
    output sts_pkg::t_rem_stat   o_stat
);

    logic                          r_busy;
    logic                          r_done;
    logic [sts_pkg::STEP_W-1:0]    r_cnt;
    logic [sts_pkg::PERIOD_W-1:0]  r_rem;
    logic [sts_pkg::BASE_W-1:0]    r_dvd;
    logic [sts_pkg::PERIOD_W-1:0]  r_dsr;

    logic [sts_pkg::PERIOD_W:0]    trial;
    logic                          fits;
    logic [sts_pkg::PERIOD_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[sts_pkg::BASE_W-1]};
        fits  = (trial >= {1'b0, r_dsr});
        // The partial remainder stays below the divisor, so the top bit is
        // zero whenever no subtraction takes place.
        if (fits) begin
            n_rem = sts_pkg::PERIOD_W'(trial - {1'b0, r_dsr});
        end else begin
            n_rem = trial[sts_pkg::PERIOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == sts_pkg::STEP_W'(sts_pkg::BASE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[sts_pkg::BASE_W-2:0], 1'b0};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.zero = (r_rem == '0);

endmodule

// ----- sv/software_timer_slot_scheduler.sv -----
// Top level of the timer slot scheduler: slot table, prescaler and sequencer.
// Depends on sts_pkg, sts_rem_unit and software_timer_slot_scheduler_defines.svh.
//
//  Channel   Direction  Handshake                Payload
//  request   in         i_valid / o_stall        command, task id, one-shot, period
//  result    out        o_valid / i_stall        kind, status, fired task, fired, last
//  config    in         i_cfg_we                 ticks per count (8 bits)
//
// Start, stop, tick and a dispatch without a pending tick go through the reply state to the
// result. A pending dispatch walks the slots with the shared remainder unit: an empty slot
// is passed over, a valid one takes check, sixteen divide steps and done; then the emit pass
// walks up to the last firing slot, or a reply follows when nothing fires.
// Reset is synchronous and empties all slots; the table is usable right after it.
// A stalled output holds the request in progress; the next request is taken once idle.
`include "software_timer_slot_scheduler_defines.svh"

module software_timer_slot_scheduler (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_command,
    input  logic [sts_pkg::TASK_W-1:0]       i_task_id,
    input  logic                             i_one_shot,
    input  logic [sts_pkg::PERIOD_W-1:0]     i_period_ticks,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [1:0]                       o_reply_kind,
    output logic [1:0]                       o_status,
    output logic [sts_pkg::TASK_W-1:0]       o_fired_task,
    output logic                             o_fired,
    output logic                             o_last,
    input  logic                             i_cfg_we,
    input  logic [sts_pkg::PRESCALE_W-1:0]   i_cfg_data
);

    localparam int N  = sts_pkg::SLOTS;
    localparam int IW = sts_pkg::SLOT_W;

    sts_pkg::t_state                     r_state, n_state;
    logic [sts_pkg::PRESCALE_W-1:0]      r_tpc;
    logic [sts_pkg::PRESCALE_W-1:0]      r_prescale;
    logic [sts_pkg::BASE_W-1:0]          r_base;
    logic                                r_pending;
    logic [N-1:0]                        r_valid;
    logic [sts_pkg::TASK_W-1:0]          r_task   [N];
    logic [N-1:0]                        r_once;
    logic [sts_pkg::PERIOD_W-1:0]        r_period [N];
    sts_pkg::t_cmd                       r_kind;
    sts_pkg::t_status                    r_status;
    logic [IW-1:0]                       r_idx;
    logic [N-1:0]                        r_mask, n_mask;

    logic                                r_o_valid;
    sts_pkg::t_cmd                       r_o_kind;
    sts_pkg::t_status                    r_o_status;
    logic [sts_pkg::TASK_W-1:0]          r_o_task;
    logic                                r_o_fired;
    logic                                r_o_last;

    sts_pkg::t_cmd                       cmd;
    logic                                accept;
    logic                                out_room;
    logic                                free_found, match_found;
    logic [IW-1:0]                       free_idx, match_idx;
    logic                                idx_last;
    logic                                cur_check;
    logic [N-1:0]                        later;
    logic                                rest_empty;
    logic [sts_pkg::PRESCALE_W-1:0]      n_prescale;

    logic                                rem_start, step_idx, emit_fire, emit_skip, reply_load;

    sts_pkg::t_rem_req                   rem_req;
    sts_pkg::t_rem_stat                  rem_stat;

    sts_rem_unit u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_stat  (rem_stat)
    );

    assign cmd      = sts_pkg::t_cmd'(i_command);
    assign accept   = i_valid && (r_state == sts_pkg::S_IDLE);
    assign out_room = !r_o_valid || !i_stall;
    assign idx_last = (r_idx == IW'(N - 1));
    assign cur_check = r_valid[r_idx] && (r_period[r_idx] != '0);
    assign n_prescale = r_prescale + 1'b1;

    // Lowest free slot and lowest valid slot holding the requested id.
    always_comb begin
        free_found  = 1'b0;
        free_idx    = '0;
        match_found = 1'b0;
        match_idx   = '0;
        for (int j = N - 1; j >= 0; j--) begin
            if (!r_valid[j]) begin
                free_found = 1'b1;
                free_idx   = IW'(j);
            end
            if (r_valid[j] && (r_task[j] == i_task_id)) begin
                match_found = 1'b1;
                match_idx   = IW'(j);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < N; j++) begin
            later[j] = r_mask[j] && (j > int'(r_idx));
        end
        rest_empty = (later == '0);
    end

    always_comb begin
        n_mask = r_mask;
        if (r_state == sts_pkg::S_WAIT && rem_stat.done && rem_stat.zero) begin
            n_mask[r_idx] = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sts_pkg::S_IDLE: begin
                if (accept) begin
                    if (cmd == sts_pkg::CMD_DISPATCH && r_pending) begin
                        n_state = sts_pkg::S_CHECK;
                    end else begin
                        n_state = sts_pkg::S_REPLY;
                    end
                end
            end
            sts_pkg::S_REPLY: begin
                if (out_room) begin
                    n_state = sts_pkg::S_IDLE;
                end
            end
            sts_pkg::S_CHECK: begin
                if (cur_check) begin
                    n_state = sts_pkg::S_WAIT;
                end else if (idx_last) begin
                    n_state = (n_mask == '0) ? sts_pkg::S_REPLY : sts_pkg::S_EMIT;
                end
            end
            sts_pkg::S_WAIT: begin
                if (rem_stat.done) begin
                    if (idx_last) begin
                        n_state = (n_mask == '0) ? sts_pkg::S_REPLY : sts_pkg::S_EMIT;
                    end else begin
                        n_state = sts_pkg::S_CHECK;
                    end
                end
            end
            sts_pkg::S_EMIT: begin
                if (r_mask[r_idx] && out_room && rest_empty) begin
                    n_state = sts_pkg::S_IDLE;
                end
            end
            default: n_state = sts_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        rem_start  = 1'b0;
        step_idx   = 1'b0;
        emit_fire  = 1'b0;
        emit_skip  = 1'b0;
        reply_load = 1'b0;
        case (r_state)
            sts_pkg::S_REPLY: reply_load = out_room;
            sts_pkg::S_CHECK: begin
                rem_start = cur_check;
                step_idx  = !cur_check;
            end
            sts_pkg::S_WAIT:  step_idx = rem_stat.done;
            sts_pkg::S_EMIT: begin
                emit_fire = r_mask[r_idx] && out_room;
                emit_skip = !r_mask[r_idx];
            end
            default: begin
                rem_start = 1'b0;
            end
        endcase
    end

    assign rem_req.start    = rem_start;
    assign rem_req.dividend = r_base;
    assign rem_req.divisor  = r_period[r_idx];

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sts_pkg::S_IDLE;
            r_tpc      <= sts_pkg::TPC_RESET;
            r_prescale <= '0;
            r_base     <= '0;
            r_pending  <= 1'b0;
            r_valid    <= '0;
            r_mask     <= '0;
            r_idx      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_tpc <= i_cfg_data;
            end

            if (accept) begin
                case (cmd)
                    sts_pkg::CMD_START: begin
                        if (i_period_ticks != '0 && free_found) begin
                            r_valid[free_idx] <= 1'b1;
                        end
                    end
                    sts_pkg::CMD_STOP: begin
                        if (match_found) begin
                            r_valid[match_idx] <= 1'b0;
                        end
                    end
                    sts_pkg::CMD_TICK: begin
                        if (n_prescale >= r_tpc) begin
                            r_prescale <= '0;
                            r_base     <= r_base + 1'b1;
                            r_pending  <= 1'b1;
                        end else begin
                            r_prescale <= n_prescale;
                        end
                    end
                    sts_pkg::CMD_DISPATCH: begin
                        r_pending <= 1'b0;
                        r_idx     <= '0;
                        r_mask    <= '0;
                    end
                    default: r_pending <= r_pending;
                endcase
            end

            if (r_state == sts_pkg::S_WAIT) begin
                r_mask <= n_mask;
            end

            // The walk restarts at slot zero for the emit pass.
            if (step_idx) begin
                r_idx <= idx_last ? '0 : r_idx + 1'b1;
            end
            if (emit_skip || (emit_fire && !rest_empty)) begin
                r_idx <= r_idx + 1'b1;
            end
            if (emit_fire) begin
                r_mask[r_idx] <= 1'b0;
                if (r_once[r_idx]) begin
                    r_valid[r_idx] <= 1'b0;
                end
            end

            if (reply_load || emit_fire) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Slot payload and result fields.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= cmd;
            case (cmd)
                sts_pkg::CMD_START: begin
                    if (i_period_ticks == '0) begin
                        r_status <= sts_pkg::ST_ZERO_PERIOD;
                    end else if (free_found) begin
                        r_status           <= sts_pkg::ST_OK;
                        r_task[free_idx]   <= i_task_id;
                        r_once[free_idx]   <= i_one_shot;
                        r_period[free_idx] <= i_period_ticks;
                    end else begin
                        r_status <= sts_pkg::ST_MISS;
                    end
                end
                sts_pkg::CMD_STOP: begin
                    r_status <= match_found ? sts_pkg::ST_OK : sts_pkg::ST_MISS;
                end
                default: r_status <= sts_pkg::ST_OK;
            endcase
        end

        if (reply_load) begin
            r_o_kind   <= r_kind;
            r_o_status <= r_status;
            r_o_task   <= '0;
            r_o_fired  <= 1'b0;
            r_o_last   <= 1'b1;
        end else if (emit_fire) begin
            r_o_kind   <= sts_pkg::CMD_DISPATCH;
            r_o_status <= sts_pkg::ST_OK;
            r_o_task   <= r_task[r_idx];
            r_o_fired  <= 1'b1;
            r_o_last   <= rest_empty;
        end
    end

    assign o_stall      = (r_state != sts_pkg::S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_reply_kind = r_o_kind;
    assign o_status     = r_o_status;
    assign o_fired_task = r_o_task;
    assign o_fired      = r_o_fired;
    assign o_last       = r_o_last;

    `STS_ASSERT_IMP(a_rem_busy_in_wait, rem_stat.busy, r_state == sts_pkg::S_WAIT)
    `STS_ASSERT_IMP(a_rem_idle_on_accept, accept, !rem_stat.busy)
    `STS_ASSERT_IMP(a_fire_is_dispatch, o_valid && o_fired,
                    o_reply_kind == sts_pkg::CMD_DISPATCH && o_status == sts_pkg::ST_OK)
    `STS_ASSERT_NEXT(a_mask_only_shrinks, r_state == sts_pkg::S_EMIT, (r_mask & ~$past(r_mask)) == '0)

endmodule
